// ----- rtl/sfa_pkg.sv -----
package sfa_pkg;

    // Table size
    localparam int SLOTS_DEFAULT = 16;

    // Field widths
    localparam int CMD_W    = 3;
    localparam int IDX_W    = 4;
    localparam int FLAGS_W  = 3;
    localparam int TILE_W   = 8;
    localparam int DELAY_W  = 15;
    localparam int TIMER_W  = 16;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 16;

    // Commands
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SELECT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESUME = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd4;

    // Mode flag bit positions
    localparam int FLAG_LOOP_BIT = 0;
    localparam int FLAG_BACK_BIT = 1;
    localparam int FLAG_STOP_BIT = 2;

    localparam logic [TILE_W-1:0] TILE_MAX = 8'd255;

    typedef struct packed {
        logic [DELAY_W-1:0] frame_delay;
        logic [TILE_W-1:0]  last_tile;
        logic [TILE_W-1:0]  first_tile;
    } entry_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [DELAY_W-1:0] elapsed_ms;
        logic [IDX_W-1:0]   anim_index;
        logic [FLAGS_W-1:0] anim_flags;
        logic               has_followup;
        logic [IDX_W-1:0]   followup_index;
        logic [FLAGS_W-1:0] followup_mode;
        entry_t             entry;
    } item_t;

    typedef struct packed {
        logic [TILE_W-1:0] tile_index;
        logic              tile_changed;
        logic [IDX_W-1:0]  active_animation;
        logic              stopped;
        logic              sequence_ended;
    } result_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] slot;
        entry_t           data;
    } wr_t;

endpackage

// ----- rtl/sfa_table_mem.sv -----
module sfa_table_mem #(
    parameter int SLOTS = sfa_pkg::SLOTS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         re,
    input  logic [sfa_pkg::IDX_W-1:0]    ra_idx,
    input  logic [sfa_pkg::IDX_W-1:0]    rb_idx,
    input  sfa_pkg::wr_t                 wr,
    output sfa_pkg::entry_t              rd_a,
    output sfa_pkg::entry_t              rd_b
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    sfa_pkg::entry_t mem [SLOTS];
    sfa_pkg::entry_t rd_a_reg;
    sfa_pkg::entry_t rd_b_reg;

    logic [AW+sfa_pkg::IDX_W-1:0] ra_wide, rb_wide, wa_wide;
    logic [AW-1:0]                ra_addr, rb_addr, wa_addr;

    // Index to address: widen, then keep the address bits
    assign ra_wide = {{AW{1'b0}}, ra_idx};
    assign rb_wide = {{AW{1'b0}}, rb_idx};
    assign wa_wide = {{AW{1'b0}}, wr.slot};
    assign ra_addr = ra_wide[AW-1:0];
    assign rb_addr = rb_wide[AW-1:0];
    assign wa_addr = wa_wide[AW-1:0];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wa_addr] <= wr.data;
        end
    end

    // Two read ports, write data forwarded on a same-edge hit
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_a_reg <= (wr.en && wa_addr == ra_addr) ? wr.data : mem[ra_addr];
            rd_b_reg <= (wr.en && wa_addr == rb_addr) ? wr.data : mem[rb_addr];
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

// ----- rtl/sfa_engine.sv -----
module sfa_engine #(
    parameter int SLOTS = sfa_pkg::SLOTS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  sfa_pkg::item_t   item,
    input  sfa_pkg::entry_t  rd_a,
    input  sfa_pkg::entry_t  rd_b,
    output sfa_pkg::result_t res,
    output sfa_pkg::wr_t     wr
);

    // Animator state
    logic [sfa_pkg::TILE_W-1:0]  tile_reg, tile_next;
    logic [sfa_pkg::IDX_W-1:0]   cur_idx_reg, cur_idx_next;
    logic [sfa_pkg::TIMER_W-1:0] timer_reg, timer_next;
    logic [sfa_pkg::FLAGS_W-1:0] mode_reg, mode_next;
    logic                        fu_valid_reg, fu_valid_next;
    logic [sfa_pkg::IDX_W-1:0]   fu_slot_reg, fu_slot_next;
    logic [sfa_pkg::FLAGS_W-1:0] fu_flags_reg, fu_flags_next;

    // Cached table entries of the current and the follow-up animation
    sfa_pkg::entry_t cur_ent_reg, cur_ent_next;
    sfa_pkg::entry_t fu_ent_reg, fu_ent_next;

    logic                        idx_ok, fu_ok;
    logic [sfa_pkg::TIMER_W-1:0] timer_dec;
    logic [sfa_pkg::TILE_W-1:0]  step_tile, wrap_tile, move_tile;
    logic                        leaves;
    logic                        at_end;
    logic                        ended;

    assign idx_ok = (32'(item.anim_index) < 32'(SLOTS));
    assign fu_ok  = !item.has_followup || (32'(item.followup_index) < 32'(SLOTS));

    // Timer countdown and tile step on the cached entry
    assign timer_dec = timer_reg - {1'b0, item.elapsed_ms};
    assign step_tile = mode_reg[sfa_pkg::FLAG_BACK_BIT] ? (tile_reg - 8'd1) : (tile_reg + 8'd1);
    assign leaves    = mode_reg[sfa_pkg::FLAG_BACK_BIT]
                     ? ((step_tile < cur_ent_reg.first_tile) || (step_tile == sfa_pkg::TILE_MAX))
                     : (step_tile > cur_ent_reg.last_tile);
    assign wrap_tile = mode_reg[sfa_pkg::FLAG_BACK_BIT] ? cur_ent_reg.last_tile
                                                         : cur_ent_reg.first_tile;
    assign at_end    = leaves && !mode_reg[sfa_pkg::FLAG_LOOP_BIT];
    assign move_tile = leaves ? wrap_tile : step_tile;

    // Next state per command
    always_comb
    begin
        tile_next     = tile_reg;
        cur_idx_next  = cur_idx_reg;
        timer_next    = timer_reg;
        mode_next     = mode_reg;
        fu_valid_next = fu_valid_reg;
        fu_slot_next  = fu_slot_reg;
        fu_flags_next = fu_flags_reg;
        cur_ent_next  = cur_ent_reg;
        fu_ent_next   = fu_ent_reg;
        ended         = 1'b0;
        wr.en         = 1'b0;
        wr.slot       = item.anim_index;
        wr.data       = item.entry;

        case (item.command)
            sfa_pkg::CMD_TICK:
            begin
                if (!mode_reg[sfa_pkg::FLAG_STOP_BIT])
                begin
                    timer_next = timer_dec;
                    if (timer_dec[sfa_pkg::TIMER_W-1])
                    begin
                        timer_next = timer_dec + {1'b0, cur_ent_reg.frame_delay};
                        if (!at_end)
                        begin
                            tile_next = move_tile;
                        end
                        else
                        begin
                            ended = 1'b1;
                            if (fu_valid_reg)
                            begin
                                // follow-up starts with its flags, no further follow-up
                                fu_valid_next = 1'b0;
                                fu_slot_next  = '0;
                                fu_flags_next = '0;
                                mode_next     = fu_flags_reg;
                                if (fu_slot_reg != cur_idx_reg)
                                begin
                                    cur_idx_next = fu_slot_reg;
                                    cur_ent_next = fu_ent_reg;
                                    timer_next   = {1'b0, fu_ent_reg.frame_delay};
                                    tile_next    = fu_flags_reg[sfa_pkg::FLAG_BACK_BIT]
                                                 ? fu_ent_reg.last_tile
                                                 : fu_ent_reg.first_tile;
                                end
                            end
                            else
                            begin
                                mode_next[sfa_pkg::FLAG_STOP_BIT] = 1'b1;
                            end
                        end
                    end
                end
            end
            sfa_pkg::CMD_SELECT:
            begin
                if (idx_ok && fu_ok)
                begin
                    fu_valid_next = item.has_followup;
                    fu_slot_next  = item.has_followup ? item.followup_index : '0;
                    fu_flags_next = item.has_followup ? item.followup_mode : '0;
                    fu_ent_next   = rd_b;
                    mode_next     = item.anim_flags;
                    if (item.anim_index != cur_idx_reg)
                    begin
                        cur_idx_next = item.anim_index;
                        cur_ent_next = rd_a;
                        timer_next   = {1'b0, rd_a.frame_delay};
                        tile_next    = item.anim_flags[sfa_pkg::FLAG_BACK_BIT]
                                     ? rd_a.last_tile : rd_a.first_tile;
                    end
                end
            end
            sfa_pkg::CMD_STOP:
            begin
                mode_next[sfa_pkg::FLAG_STOP_BIT] = 1'b1;
            end
            sfa_pkg::CMD_RESUME:
            begin
                mode_next[sfa_pkg::FLAG_STOP_BIT] = 1'b0;
            end
            sfa_pkg::CMD_WRITE:
            begin
                if (idx_ok)
                begin
                    wr.en = fire;
                    // keep the cached copies in step with the table
                    if (item.anim_index == cur_idx_reg)
                    begin
                        cur_ent_next = item.entry;
                    end
                    if (item.anim_index == fu_slot_reg)
                    begin
                        fu_ent_next = item.entry;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_reg     <= '0;
            cur_idx_reg  <= '0;
            timer_reg    <= '0;
            mode_reg     <= 3'b100;
            fu_valid_reg <= 1'b0;
            fu_slot_reg  <= '0;
            fu_flags_reg <= '0;
        end
        else if (fire)
        begin
            tile_reg     <= tile_next;
            cur_idx_reg  <= cur_idx_next;
            timer_reg    <= timer_next;
            mode_reg     <= mode_next;
            fu_valid_reg <= fu_valid_next;
            fu_slot_reg  <= fu_slot_next;
            fu_flags_reg <= fu_flags_next;
        end
    end

    // Cached entries
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            cur_ent_reg <= cur_ent_next;
            fu_ent_reg  <= fu_ent_next;
        end
    end

    // Result of the item being retired
    assign res.tile_index       = tile_next;
    assign res.tile_changed     = (tile_next != tile_reg);
    assign res.active_animation = cur_idx_next;
    assign res.stopped          = mode_next[sfa_pkg::FLAG_STOP_BIT];
    assign res.sequence_ended   = ended;

endmodule

// ----- rtl/sprite_frame_animator.sv -----
// Sprite frame animator: one result transfer for each input transfer.
// Result path: the table read and the item stage load at the input transfer; the state
// update and result register load once the stage retires to a free or draining output.
// Throughput: 1 item per cycle unless m_tready stalls; the table read is issued
// on input transfer, the state update with table write-back when the stage retires.
// Reset: asynchronous, active low; animator stopped on animation 0, tile 0, no follow-up.
// The animation table is not cleared; entries hold no defined value until written.
module sprite_frame_animator #(
    parameter int ANIMATION_SLOTS = sfa_pkg::SLOTS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [14:0] elapsed_ms, [18:15] anim_index, [21:19] anim_flags, [22] has_followup,
    // [26:23] followup_index, [29:27] followup_mode, [37:30] entry first tile,
    // [45:38] entry last tile, [60:46] entry frame delay, [63:61] zero
    input  logic [sfa_pkg::IN_TDATA_W-1:0]    s_tdata,
    // [2:0] command
    input  logic [sfa_pkg::CMD_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] tile_index, [8] tile_changed, [12:9] active_animation, [13] stopped,
    // [14] sequence_ended, [15] zero
    output logic [sfa_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    sfa_pkg::item_t   in_item;
    sfa_pkg::item_t   stg_item_reg;
    logic             stg_valid_reg, stg_valid_next;
    logic             out_valid_reg, out_valid_next;
    sfa_pkg::result_t out_res_reg;
    sfa_pkg::result_t res;
    sfa_pkg::wr_t     wr;
    sfa_pkg::entry_t  rd_a, rd_b;
    logic             accept, advance;

    // Unpack the input transfer
    assign in_item.command           = s_tuser;
    assign in_item.elapsed_ms        = s_tdata[14:0];
    assign in_item.anim_index        = s_tdata[18:15];
    assign in_item.anim_flags        = s_tdata[21:19];
    assign in_item.has_followup      = s_tdata[22];
    assign in_item.followup_index    = s_tdata[26:23];
    assign in_item.followup_mode     = s_tdata[29:27];
    assign in_item.entry.first_tile  = s_tdata[37:30];
    assign in_item.entry.last_tile   = s_tdata[45:38];
    assign in_item.entry.frame_delay = s_tdata[60:46];

    // Handshake: stage retires when the output register is free or draining
    assign advance  = stg_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !stg_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign stg_valid_next = accept ? 1'b1 : (advance ? 1'b0 : stg_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item stage and result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_item_reg <= in_item;
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    sfa_table_mem #(
        .SLOTS (ANIMATION_SLOTS)
    ) u_table (
        .clk    (clk),
        .re     (accept),
        .ra_idx (in_item.anim_index),
        .rb_idx (in_item.followup_index),
        .wr     (wr),
        .rd_a   (rd_a),
        .rd_b   (rd_b)
    );

    sfa_engine #(
        .SLOTS (ANIMATION_SLOTS)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (stg_item_reg),
        .rd_a  (rd_a),
        .rd_b  (rd_b),
        .res   (res),
        .wr    (wr)
    );

    // Pack the result transfer
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_res_reg.sequence_ended,
                       out_res_reg.stopped,
                       out_res_reg.active_animation,
                       out_res_reg.tile_changed,
                       out_res_reg.tile_index};

endmodule
